// ----- rtl/sat_pkg.sv -----
// shared types and constants for the segment address translator
// no dependencies; imported by every other file of the block
`default_nettype none

package sat_pkg;

    localparam int NUM_SEGMENTS_DEF = 32;

    localparam int SLOT_IDX_W = 5;
    localparam int VBASE_W    = 47;
    localparam int LEN_W      = 48;
    localparam int PBASE_W    = 52;
    localparam int ADDR_W     = 64;
    localparam int VA_BITS    = 47;
    localparam int PAGE_SHIFT = 21;

    // segment end (base + length) and physical offset (phys - base)
    localparam int END_W   = 49;
    localparam int DELTA_W = 53;

    localparam int S_TDATA_W = SLOT_IDX_W + VBASE_W + LEN_W + PBASE_W + ADDR_W;
    localparam int M_TDATA_W = ADDR_W;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_XLATE = 1'b1
    } op_t;

    // item travelling down the row of cells
    typedef struct packed {
        logic                  valid;
        op_t                   op;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [VBASE_W-1:0]    seg_virt_base;
        logic [LEN_W-1:0]      seg_length;
        logic [PBASE_W-1:0]    seg_phys_base;
        logic [VA_BITS-1:0]    vaddr;
        logic                  done;
        logic                  found;
        logic [DELTA_W-1:0]    delta;
    } token_t;

endpackage

`default_nettype wire

// ----- rtl/sat_cell.sv -----
// one segment slot of the translator row, with its pipeline register
// depends on sat_pkg
`default_nettype none

module sat_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire sat_pkg::token_t tok_in,
    output sat_pkg::token_t     tok_out
);
    import sat_pkg::*;

    logic [VBASE_W-1:0] base_reg;
    logic [END_W-1:0]   seg_end_reg;
    logic [DELTA_W-1:0] delta_reg;
    token_t             tok_reg;
    token_t             tok_next;

    logic               wr_hit;
    logic               in_seg;
    logic [VBASE_W-1:0] aligned;

    assign aligned = {tok_in.vaddr[VA_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign wr_hit  = tok_in.valid && (tok_in.op == OP_WRITE)
                     && (32'(tok_in.slot_index) == CELL_ID);
    assign in_seg  = (aligned >= base_reg)
                     && ({{(END_W-VBASE_W){1'b0}}, aligned} < seg_end_reg);

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && (tok_in.op == OP_XLATE) && !tok_in.done) begin
            if (base_reg == '0) begin
                // empty slot ends the search
                tok_next.done = 1'b1;
            end else if (in_seg) begin
                tok_next.done  = 1'b1;
                tok_next.found = 1'b1;
                tok_next.delta = delta_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (en && wr_hit) begin
            base_reg <= tok_in.seg_virt_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && wr_hit) begin
            seg_end_reg <= {{(END_W-VBASE_W){1'b0}}, tok_in.seg_virt_base}
                           + {{(END_W-LEN_W){1'b0}}, tok_in.seg_length};
            delta_reg   <= {{(DELTA_W-PBASE_W){1'b0}}, tok_in.seg_phys_base}
                           - {{(DELTA_W-VBASE_W){1'b0}}, tok_in.seg_virt_base};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (en) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ----- rtl/sat_result.sv -----
// result stage: forms the physical address and holds it for the m_ side
// depends on sat_pkg
`default_nettype none

module sat_result (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sat_pkg::token_t tok_last,
    input  wire logic            m_tready,
    output logic                 m_tvalid,
    output logic [sat_pkg::ADDR_W-1:0] xlat_addr,
    output logic                 found,
    output logic                 chain_en
);
    import sat_pkg::*;

    logic               valid_reg;
    logic [ADDR_W-1:0]  xlat_addr_reg;
    logic               found_reg;
    logic               last_xlate;
    logic [DELTA_W-1:0] paddr;
    logic [ADDR_W-1:0]  xlat_addr_next;

    assign last_xlate = tok_last.valid && (tok_last.op == OP_XLATE);
    // row moves unless a result would land on an untaken one
    assign chain_en   = !last_xlate || !valid_reg || m_tready;

    assign paddr = {{(DELTA_W-VA_BITS){1'b0}},
                    tok_last.vaddr[VA_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
                   + tok_last.delta;

    always_comb begin
        if (tok_last.found) begin
            xlat_addr_next = {{(ADDR_W-DELTA_W){1'b0}},
                              paddr[DELTA_W-1:PAGE_SHIFT],
                              tok_last.vaddr[PAGE_SHIFT-1:0]};
        end else begin
            xlat_addr_next = '1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (chain_en && last_xlate) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (chain_en && last_xlate) begin
            xlat_addr_reg <= xlat_addr_next;
            found_reg     <= tok_last.found;
        end
    end

    assign m_tvalid  = valid_reg;
    assign xlat_addr = xlat_addr_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

// ----- rtl/segment_address_translator_top.sv -----
// an s_ transfer reaches its m_ transfer through the register of each slot cell and then the result register
// throughput: one item per cycle while m_tready is high; the row of slot
//   cells is a pipeline, each cell holding one segment and passing the item on
// a translate reaching a full result register with m_tready low stalls the whole row
// reset clears every segment base (all slots empty) and drops items in flight
`default_nettype none

module segment_address_translator_top #(
    parameter int NUM_SEGMENTS = sat_pkg::NUM_SEGMENTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // slot_index[4:0], seg_virt_base[51:5], seg_length[99:52],
    // seg_phys_base[151:100], virt_addr[215:152]
    input  wire logic [sat_pkg::S_TDATA_W-1:0] s_tdata,
    // op: 0 write a segment slot, 1 translate
    input  wire logic                          s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // xlat_addr[63:0]
    output logic [sat_pkg::M_TDATA_W-1:0]      m_tdata,
    // found
    output logic                               m_tuser
);
    import sat_pkg::*;

    localparam int IDX_LO   = 0;
    localparam int VBASE_LO = IDX_LO + SLOT_IDX_W;
    localparam int LEN_LO   = VBASE_LO + VBASE_W;
    localparam int PBASE_LO = LEN_LO + LEN_W;
    localparam int ADDR_LO  = PBASE_LO + PBASE_W;

    token_t tok [0:NUM_SEGMENTS];
    logic   chain_en;
    logic [ADDR_W-1:0] virt_addr;

    assign virt_addr = s_tdata[ADDR_LO +: ADDR_W];

    // item entering the first cell; high address bits end the search at once
    always_comb begin
        tok[0].valid         = s_tvalid && s_tready;
        tok[0].op            = op_t'(s_tuser);
        tok[0].slot_index    = s_tdata[IDX_LO +: SLOT_IDX_W];
        tok[0].seg_virt_base = s_tdata[VBASE_LO +: VBASE_W];
        tok[0].seg_length    = s_tdata[LEN_LO +: LEN_W];
        tok[0].seg_phys_base = s_tdata[PBASE_LO +: PBASE_W];
        tok[0].vaddr         = virt_addr[VA_BITS-1:0];
        tok[0].done          = (op_t'(s_tuser) == OP_XLATE)
                               && (virt_addr[ADDR_W-1:VA_BITS] != '0);
        tok[0].found         = 1'b0;
        tok[0].delta         = '0;
    end

    // row of slot cells, one per segment
    for (genvar i = 0; i < NUM_SEGMENTS; i++) begin : g_cell
        sat_cell #(
            .CELL_ID (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (chain_en),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // write items leave the row here without a result transfer
    sat_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_last  (tok[NUM_SEGMENTS]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .xlat_addr (m_tdata),
        .found     (m_tuser),
        .chain_en  (chain_en)
    );

    assign s_tready = chain_en;

    // a miss always carries the all-ones address
    a_miss_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '1))
        else $error("miss result without all-ones address");

    // a hit frame never exceeds 53 address bits
    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[ADDR_W-1:DELTA_W] == '0))
        else $error("hit result above 53 bits");

    // a ready consumer never stalls the input side
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with consumer ready");

endmodule

`default_nettype wire
